// ===== hdl/csdm_pkg.sv =====
//------------------------------------------------------------------------------
// csdm_pkg
// shared constants, types and tables for the concentric square-to-disk map
//------------------------------------------------------------------------------
`default_nettype none
package csdm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int AB_W          = 18;   // a, b in signed Q1.16 plus headroom
  localparam int CORDIC_ITERS  = 30;
  localparam int CW            = 34;   // cordic x/y/z word, Q.30 plus headroom
  localparam int ITER_W        = 5;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [31:0]          QPI_Q30     = 32'd843314857;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_2 = 2'd1;
  localparam quad_t QUAD_4 = 2'd2;
  localparam quad_t QUAD_6 = 2'd3;

  // side info that rides along with each request
  typedef struct packed {
    logic        vld;
    quad_t       quad;
    logic [16:0] rad;    // radius magnitude, Q.16, at most 1.0
  } tag_t;

  function automatic logic signed [CW-1:0] atan_tab(input logic [ITER_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(843314856);
      5'd1:  v = CW'(497837829);
      5'd2:  v = CW'(263043836);
      5'd3:  v = CW'(133525158);
      5'd4:  v = CW'(67021686);
      5'd5:  v = CW'(33543515);
      5'd6:  v = CW'(16775850);
      5'd7:  v = CW'(8388437);
      5'd8:  v = CW'(4194282);
      5'd9:  v = CW'(2097149);
      5'd10: v = CW'(1048575);
      5'd11: v = CW'(524287);
      5'd12: v = CW'(262143);
      5'd13: v = CW'(131071);
      5'd14: v = CW'(65535);
      5'd15: v = CW'(32767);
      5'd16: v = CW'(16383);
      5'd17: v = CW'(8191);
      5'd18: v = CW'(4095);
      5'd19: v = CW'(2047);
      5'd20: v = CW'(1023);
      5'd21: v = CW'(511);
      5'd22: v = CW'(255);
      5'd23: v = CW'(127);
      5'd24: v = CW'(63);
      5'd25: v = CW'(31);
      5'd26: v = CW'(15);
      5'd27: v = CW'(7);
      5'd28: v = CW'(3);
      5'd29: v = CW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/csdm_div_cell.sv =====
//------------------------------------------------------------------------------
// csdm_div_cell
// one restoring-divide step of the ratio divider chain
//------------------------------------------------------------------------------
`default_nettype none
module csdm_div_cell #(
  parameter int QW = 18,   // quotient width
  parameter int DW = 17    // divisor width
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW:0]   rem_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic [DW-1:0] num_i,   // numerator bits still to shift in, msb first
  input  wire csdm_pkg::tag_t tag_i,
  output logic      [DW:0]   rem_o,
  output logic      [DW-1:0] den_o,
  output logic      [QW-1:0] q_o,
  output logic      [DW-1:0] num_o,
  output csdm_pkg::tag_t     tag_o
);
  import csdm_pkg::*;

  logic [DW+1:0] shl;
  logic [DW+1:0] diff;
  logic          ge;

  assign shl  = {rem_i, num_i[DW-1]};
  assign diff = shl - {2'b00, den_i};
  assign ge   = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DW:0] : shl[DW:0];
      den_o <= den_i;
      q_o   <= {q_i[QW-2:0], ge};
      num_o <= {num_i[DW-2:0], 1'b0};
      tag_o <= tag_i;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/csdm_cordic_cell.sv =====
//------------------------------------------------------------------------------
// csdm_cordic_cell
// one rotation-mode cordic iteration with fixed shift
//------------------------------------------------------------------------------
`default_nettype none
module csdm_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [csdm_pkg::CW-1:0] x_i,
  input  wire logic signed [csdm_pkg::CW-1:0] y_i,
  input  wire logic signed [csdm_pkg::CW-1:0] z_i,
  input  wire csdm_pkg::tag_t tag_i,
  output logic signed [csdm_pkg::CW-1:0] x_o,
  output logic signed [csdm_pkg::CW-1:0] y_o,
  output logic signed [csdm_pkg::CW-1:0] z_o,
  output csdm_pkg::tag_t tag_o
);
  import csdm_pkg::*;

  localparam logic signed [CW-1:0] ANG = atan_tab(ITER_W'(STEP));

  logic signed [CW-1:0] dx, dy;
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[CW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ANG;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ANG;
      end
      tag_o <= tag_i;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/concentric_square_to_disk_map_core.sv =====
//------------------------------------------------------------------------------
// concentric_square_to_disk_map_core
// streaming concentric square-to-disk map: sector pick, divider chain,
// cordic chain and scaling, fully pipelined
//------------------------------------------------------------------------------
// channel  dir  tdata (low bit up)          notes
// in_      in   square_x[15:0] square_y     one sample per request
// out_     out  disk_x[15:0] disk_y         one point per request
//
// one request per cycle sustained while the output is not stalled; the
// stages are 1 input register, FRAC_BITS+2 divide cells, 2 angle stages,
// 30 cordic cells, 1 scale stage and 1 output register; the whole chain
// advances together only when the output slot is free, so in_tready
// follows the output register
// rst_n clears valid flags only; payload registers are not reset
//------------------------------------------------------------------------------
`default_nettype none
module concentric_square_to_disk_map_core #(
  parameter int FRAC_BITS = csdm_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // square_x, square_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata    // disk_x, disk_y
);
  import csdm_pkg::*;

  localparam int DW = 17;               // divisor / numerator magnitude width
  localparam int QW = FRAC_BITS + 2;    // quotient bits incl. integer bit
  localparam int NS = QW;               // divide cells

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- sector pick ----------------
  logic signed [AB_W-1:0] a, b, num, den;
  quad_t                  quad;
  logic [DW-1:0]          nm, dm;
  logic                   neg;

  assign a = AB_W'($signed({1'b0, in_tdata[15:0], 1'b0})) - AB_W'(65536);
  assign b = AB_W'($signed({1'b0, in_tdata[31:16], 1'b0})) - AB_W'(65536);

  always_comb begin
    if (a > -b) begin
      if (a > b) begin num = b;  den = a; quad = QUAD_0; end
      else       begin num = -a; den = b; quad = QUAD_2; end
    end else begin
      if (a < b) begin num = b;  den = a; quad = QUAD_4; end
      else       begin num = -a; den = b; quad = QUAD_6; end
    end
    nm  = num[AB_W-1] ? DW'(-num) : DW'(num);
    dm  = den[AB_W-1] ? DW'(-den) : DW'(den);
    neg = num[AB_W-1] != den[AB_W-1];
    if (den == '0) quad = QUAD_0;
  end

  // stage 0 register: pre-add dm/2 is folded into the divider as a rounded
  // quotient by dividing with one extra bit and rounding later
  logic [DW-1:0]  nm_r, dm_r;
  tag_t           tag0_r;
  logic [NS:0]    neg_sr_r;   // sign of ratio, delayed along the divide chain
  logic [NS:0]    zero_sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tag0_r.vld <= 1'b0;
    else if (en) tag0_r.vld <= in_tvalid;
    if (en) begin
      nm_r        <= nm;
      dm_r        <= dm;
      tag0_r.quad <= quad;
      tag0_r.rad  <= dm;
      neg_sr_r    <= {neg_sr_r[NS-1:0], neg};
      zero_sr_r   <= {zero_sr_r[NS-1:0], dm == '0};
    end
  end

  // ---------------- divider chain ----------------
  // computes floor(2*nm*2^F / dm), the last bit gives round-half-up
  logic [DW:0]   rem_c [NS+1];
  logic [DW-1:0] den_c [NS+1];
  logic [QW-1:0] q_c   [NS+1];
  logic [DW-1:0] num_c [NS+1];
  tag_t          tag_c [NS+1];

  // lsb of nm enters in the first cell, whose compare gives the integer bit
  assign rem_c[0] = {2'b00, nm_r[DW-1:1]};
  assign den_c[0] = (dm_r == '0) ? DW'(1) : dm_r;
  assign q_c[0]   = '0;
  assign num_c[0] = {nm_r[0], {(DW-1){1'b0}}};
  assign tag_c[0] = tag0_r;

  for (genvar g = 0; g < NS; g++) begin : g_div
    csdm_div_cell #(.QW(QW), .DW(DW)) u_cell (
      .clk(clk), .en(en),
      .rem_i(rem_c[g]), .den_i(den_c[g]), .q_i(q_c[g]), .num_i(num_c[g]),
      .tag_i(tag_c[g]),
      .rem_o(rem_c[g+1]), .den_o(den_c[g+1]), .q_o(q_c[g+1]),
      .num_o(num_c[g+1]), .tag_o(tag_c[g+1])
    );
  end

  // valid flags of the divide chain need reset
  logic [NS-1:0] dvld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dvld_r <= '0;
    else if (en) dvld_r <= {dvld_r[NS-2:0], tag0_r.vld};
  end

  // ---------------- angle: round ratio, times pi/4 ----------------
  logic [QW-1:0]   qr;
  logic [QW+31:0]  prod_r;
  tag_t            tag1_r, tag2_r;
  logic            neg1_r, zero1_r, neg2_r;
  logic signed [CW-1:0] theta_r;
  logic [QW+31:0]  trnd;

  assign qr   = QW'((q_c[NS] + QW'(1)) >> 1);
  assign trnd = (prod_r + ((QW+32)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
    end else if (en) begin
      tag1_r.vld <= dvld_r[NS-1];
      tag2_r.vld <= tag1_r.vld;
    end
    if (en) begin
      prod_r      <= (QW+32)'(qr) * (QW+32)'(QPI_Q30);
      tag1_r.quad <= tag_c[NS].quad;
      tag1_r.rad  <= tag_c[NS].rad;
      neg1_r      <= neg_sr_r[NS];
      zero1_r     <= zero_sr_r[NS];
      tag2_r.quad <= tag1_r.quad;
      tag2_r.rad  <= tag1_r.rad;
      neg2_r      <= neg1_r;
      theta_r     <= zero1_r ? '0 :
                     (neg1_r ? -CW'(trnd) : CW'(trnd));
    end
  end

  // ---------------- cordic chain ----------------
  logic signed [CW-1:0] cx [CORDIC_ITERS+1];
  logic signed [CW-1:0] cy [CORDIC_ITERS+1];
  logic signed [CW-1:0] cz [CORDIC_ITERS+1];
  tag_t                 ct [CORDIC_ITERS+1];

  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = theta_r;
  assign ct[0] = '{vld: 1'b0, quad: tag2_r.quad, rad: tag2_r.rad};

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
    csdm_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(en),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .tag_i(ct[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .tag_o(ct[g+1])
    );
  end

  logic [CORDIC_ITERS-1:0] cvld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cvld_r <= '0;
    else if (en) cvld_r <= {cvld_r[CORDIC_ITERS-2:0], tag2_r.vld};
  end

  // ---------------- quarter turn and scale ----------------
  logic signed [CW-1:0] ox, oy;
  always_comb begin
    unique case (ct[CORDIC_ITERS].quad)
      QUAD_2:  begin ox = -cy[CORDIC_ITERS]; oy =  cx[CORDIC_ITERS]; end
      QUAD_4:  begin ox = -cx[CORDIC_ITERS]; oy = -cy[CORDIC_ITERS]; end
      QUAD_6:  begin ox =  cy[CORDIC_ITERS]; oy = -cx[CORDIC_ITERS]; end
      default: begin ox =  cx[CORDIC_ITERS]; oy =  cy[CORDIC_ITERS]; end
    endcase
  end

  logic [CW-1:0]    mx, my;
  logic [CW+16:0]   px_r, py_r;
  logic             sx_r, sy_r, svld_r;

  assign mx = ox[CW-1] ? CW'(-ox) : CW'(ox);
  assign my = oy[CW-1] ? CW'(-oy) : CW'(oy);

  always_ff @(posedge clk) begin
    if (!rst_n) svld_r <= 1'b0;
    else if (en) svld_r <= cvld_r[CORDIC_ITERS-1];
    if (en) begin
      px_r <= (CW+17)'(mx) * (CW+17)'(ct[CORDIC_ITERS].rad);
      py_r <= (CW+17)'(my) * (CW+17)'(ct[CORDIC_ITERS].rad);
      sx_r <= ox[CW-1] && ct[CORDIC_ITERS].rad != '0;
      sy_r <= oy[CW-1] && ct[CORDIC_ITERS].rad != '0;
    end
  end

  function automatic logic [15:0] sat_q15(input logic [CW+16:0] p, input logic s);
    logic [CW+16:0] m;
    m = (p + ((CW+17)'(1) << 30)) >> 31;
    if (s) return (m > (CW+17)'(32768)) ? 16'h8000 : 16'(-m);
    else   return (m > (CW+17)'(32767)) ? 16'h7fff : 16'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= svld_r;
    if (en) out_tdata <= {sat_q15(py_r, sy_r), sat_q15(px_r, sx_r)};
  end

  // ---------------- checks ----------------
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready mismatch");
  a_zero_theta: assert property (@(posedge clk) disable iff (!rst_n)
    en && zero1_r |=> theta_r == '0)
    else $error("origin angle not zero");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// streams unit-square samples through the concentric disk map and checks
// every disk point against an in-bench fixed-point predictor or a listed
// value, with random idling on both sides and one long output hold-off
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csdm_pkg::*;

  localparam int LATENCY   = 18 + 2 + 30 + 2 + 1;
  localparam int N_RANDOM  = 1230;
  localparam longint LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // square_x, square_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // disk_x, disk_y

  concentric_square_to_disk_map_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected disk points, oldest first
  logic [31:0] disk_pts_due[$];
  int     n_mismatch = 0;
  int     n_points = 0;
  int     n_samples = 0;
  longint n_cycles = 0;
  bit     hold_out = 1'b0;   // long receiver hold-off
  bit     calm = 1'b0;       // stretch with no idling
  bit     stim_done = 1'b0;

  const longint ATAN_Q30[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1};

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Q.30 component times Q.16 radius, rounded to Q.15 half away, saturated
  function automatic logic [15:0] scale_to_q15(longint c, longint rad);
    longint p, m, v;
    p = c * rad;
    m = (mag(p) + (64'sd1 <<< 30)) >>> 31;
    v = (p < 0) ? -m : m;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [31:0] disk_point(logic [15:0] sx, logic [15:0] sy);
    longint a, b, rad, num, den, theta, cx, cy, z, dx, dy, ox, oy, q, t;
    quad_t quad;
    a = 2 * longint'(sx) - 65536;
    b = 2 * longint'(sy) - 65536;
    // sector pick by comparing a against b and -b
    if (a > -b) begin
      if (a > b) begin
        rad = a; num = b; den = a; quad = QUAD_0;
      end else begin
        rad = b; num = -a; den = b; quad = QUAD_2;
      end
    end else begin
      if (a < b) begin
        rad = -a; num = b; den = a; quad = QUAD_4;
      end else begin
        rad = -b; num = -a; den = b; quad = QUAD_6;
      end
    end
    theta = 0;
    if (den != 0) begin
      q = ((mag(num) << 16) + mag(den) / 2) / mag(den);
      t = (q * 843314857 + (64'sd1 << 15)) >> 16;
      theta = (((num < 0) != (den < 0)) ? -t : t);
    end else begin
      quad = QUAD_0;   // origin: zero angle
    end
    cx = 652032874; cy = 0; z = theta;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= ATAN_Q30[i];
      end else begin
        cx += dx; cy -= dy; z += ATAN_Q30[i];
      end
    end
    case (quad)
      QUAD_2: begin ox = -cy; oy = cx; end
      QUAD_4: begin ox = -cx; oy = -cy; end
      QUAD_6: begin ox = cy; oy = -cx; end
      default: begin ox = cx; oy = cy; end
    endcase
    return {scale_to_q15(oy, rad), scale_to_q15(ox, rad)};
  endfunction

  // directed samples; expected point given only where obvious, else predicted
  typedef struct {
    logic [15:0] sx;
    logic [15:0] sy;
    bit          known;
    logic [31:0] pt;
  } sample_row_t;

  sample_row_t corner_rows[] = '{
    '{16'h8000, 16'h8000, 1'b1, 32'h0000_0000},  // origin
    '{16'h0000, 16'h8000, 1'b1, 32'h0000_8000},  // full radius, left
    '{16'h8000, 16'h0000, 1'b0, 32'h0},          // full radius, down
    '{16'h0000, 16'h0000, 1'b0, 32'h0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 32'h0},
    '{16'h0000, 16'hFFFF, 1'b0, 32'h0},
    '{16'hFFFF, 16'h0000, 1'b0, 32'h0},
    '{16'hFFFF, 16'h8000, 1'b0, 32'h0},
    '{16'h8000, 16'hFFFF, 1'b0, 32'h0},
    '{16'hC000, 16'hC000, 1'b0, 32'h0},          // diagonal, sector edges
    '{16'h4000, 16'hC000, 1'b0, 32'h0},
    '{16'h4000, 16'h4000, 1'b0, 32'h0},
    '{16'hC000, 16'h4000, 1'b0, 32'h0},
    '{16'h8001, 16'h8000, 1'b0, 32'h0},          // one lsb from origin
    '{16'h8000, 16'h8001, 1'b0, 32'h0},
    '{16'h7FFF, 16'h8000, 1'b0, 32'h0},
    '{16'h8000, 16'h7FFF, 1'b0, 32'h0},
    '{16'h5555, 16'hAAAA, 1'b0, 32'h0},
    '{16'hAAAA, 16'h5555, 1'b0, 32'h0},
    '{16'hF000, 16'h9000, 1'b0, 32'h0},
    '{16'h1000, 16'h7000, 1'b0, 32'h0}
  };

  task automatic send_sample(logic [15:0] sx, logic [15:0] sy, bit known,
                             logic [31:0] pt);
    // random gap before the request, except in the calm stretch
    while (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    disk_pts_due = {disk_pts_due, (known ? pt : disk_point(sx, sy))};
    n_samples++;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [15:0] sx, sy;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (corner_rows[k])
      send_sample(corner_rows[k].sx, corner_rows[k].sy, corner_rows[k].known,
                  corner_rows[k].pt);
    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 400 && k < 600);
      case ($urandom_range(3))
        0: begin   // near the origin, at times on the x = y diagonal
          sx = 16'h8000 + 16'($urandom_range(15)) - 16'd8;
          sy = $urandom_range(1) ? sx : 16'h8000 + 16'($urandom_range(15)) - 16'd8;
        end
        1: begin   // rim of the square
          sx = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
          sy = 16'($urandom);
          if ($urandom_range(1)) {sx, sy} = {sy, sx};
        end
        default: begin
          sx = 16'($urandom);
          sy = 16'($urandom);
        end
      endcase
      send_sample(sx, sy, 1'b0, 32'h0);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off while requests keep coming
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (n_samples >= 200 && n_samples < 205 && !hold_out && n_points < 200) begin
        hold_out = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  // checker, sampled at the rising edge
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      n_points++;
      if (disk_pts_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected disk point %h", out_tdata);
      end else begin
        want = disk_pts_due.pop_front();
        if (out_tdata[15:0] !== want[15:0] || out_tdata[31:16] !== want[31:16]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("point %0d: disk_x exp %0d got %0d, disk_y exp %0d got %0d",
                     n_points, $signed(want[15:0]), $signed(out_tdata[15:0]),
                     $signed(want[31:16]), $signed(out_tdata[31:16]));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d points pending", n_cycles,
               disk_pts_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (disk_pts_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d samples (corners, origin, diagonals, rim, random), got %0d points",
             n_samples, n_points);
    $display("mismatches: %0d, long output hold-off exercised: %0d", n_mismatch, hold_out);
    if (n_mismatch == 0 && disk_pts_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
